/* hw/rtl/mdd_pkg.sv */
// Shared types and constants for the magnetic door detector.
`default_nettype none

package mdd_pkg;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_X     = 3'd0,
    CFG_COEF_Y     = 3'd1,
    CFG_COEF_Z     = 3'd2,
    CFG_OPEN_THR   = 3'd3,
    CFG_CLOSED_THR = 3'd4,
    CFG_DEBOUNCE   = 3'd5
  } cfg_idx_t;

  localparam logic [15:0] COEF_X_RST   = 16'd512;
  localparam logic [15:0] COEF_Y_RST   = 16'd512;
  localparam logic [15:0] COEF_Z_RST   = 16'd2560;
  localparam logic [14:0] OPEN_RST     = 15'd0;
  localparam logic [14:0] CLOSED_RST   = 15'd0;
  localparam logic [15:0] DEBOUNCE_RST = 16'd100;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic [15:0] coef_x;
    logic [15:0] coef_y;
    logic [15:0] coef_z;
    logic [14:0] open_thr;
    logic [14:0] closed_thr;
    logic [15:0] debounce;
  } cfg_regs_t;

endpackage

`default_nettype wire

/* hw/rtl/mdd_cfg.sv */
// Configuration register file of the door detector.
`default_nettype none

module mdd_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [mdd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mdd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output mdd_pkg::cfg_regs_t                    regs_r
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.coef_x     <= mdd_pkg::COEF_X_RST;
      regs_r.coef_y     <= mdd_pkg::COEF_Y_RST;
      regs_r.coef_z     <= mdd_pkg::COEF_Z_RST;
      regs_r.open_thr   <= mdd_pkg::OPEN_RST;
      regs_r.closed_thr <= mdd_pkg::CLOSED_RST;
      regs_r.debounce   <= mdd_pkg::DEBOUNCE_RST;
    end else if (cfg_valid) begin
      unique case (mdd_pkg::cfg_idx_t'(cfg_index))
        mdd_pkg::CFG_COEF_X:     regs_r.coef_x     <= cfg_data;
        mdd_pkg::CFG_COEF_Y:     regs_r.coef_y     <= cfg_data;
        mdd_pkg::CFG_COEF_Z:     regs_r.coef_z     <= cfg_data;
        mdd_pkg::CFG_OPEN_THR:   regs_r.open_thr   <= cfg_data[14:0];
        mdd_pkg::CFG_CLOSED_THR: regs_r.closed_thr <= cfg_data[14:0];
        mdd_pkg::CFG_DEBOUNCE:   regs_r.debounce   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mdd_mul.sv */
// Shared 16x16 unsigned multiplier with registered product.
`default_nettype none

module mdd_mul (
  input  wire logic        clk,
  input  wire logic [15:0] a,
  input  wire logic [15:0] b,
  output logic      [31:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= 32'(a) * 32'(b);
  end

endmodule

`default_nettype wire

/* hw/rtl/mdd_axis.sv */
// One axis: temperature compensation of the origin and absolute distance term.
`default_nettype none

module mdd_axis (
  input  wire logic signed [15:0] org,
  input  wire logic signed [15:0] sample,
  input  wire logic        [15:0] pmag,
  input  wire logic               delta_neg,
  output logic signed      [15:0] comp,
  output logic             [15:0] dabs
);

  logic signed [17:0] org_e;
  logic signed [17:0] pmag_e;
  logic signed [17:0] sum;
  logic        [16:0] s_abs;
  logic        [16:0] c_abs;
  logic        [16:0] diff;
  logic        [16:0] diff_neg;

  assign org_e  = {{2{org[15]}}, org};
  assign pmag_e = {2'b00, pmag};

  // add when origin and delta share a sign, subtract otherwise
  always_comb begin
    if (org[15] == delta_neg) sum = org_e + pmag_e;
    else                      sum = org_e - pmag_e;
  end

  always_comb begin
    priority if (sum > 18'sd32767)  comp = 16'sh7FFF;
    else if (sum < -18'sd32768)     comp = 16'sh8000;
    else                            comp = sum[15:0];
  end

  assign s_abs    = sample[15] ? (17'd0 - {1'b1, sample}) : {1'b0, sample};
  assign c_abs    = comp[15]   ? (17'd0 - {1'b1, comp})   : {1'b0, comp};
  assign diff     = s_abs - c_abs;
  assign diff_neg = 17'd0 - diff;
  assign dabs     = diff[16] ? diff_neg[15:0] : diff[15:0];

endmodule

`default_nettype wire

/* hw/rtl/magnetic_door_detector.sv */
// Top level of the magnetic door detector: sequencer around a shared multiplier.
//
// An item is taken when in_tready is high and then occupies the block until its
// result is loaded into the output register. A calibrate item or an event that
// falls inside the debounce gap passes only through the check and done states.
// An accepted event also runs the compensation, square and accumulate states for
// each axis and then two threshold states: the single 16x16 multiplier runs eight
// times in sequence (three compensation products, three squared axis distances,
// two squared thresholds), each result registered before use. When the previous
// result still sits unread in the output register the sequencer holds in its last
// step until out_tready frees it. Configuration writes are always ready and take
// effect on the next cycle.
`default_nettype none

module magnetic_door_detector #(
  parameter int TICK_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // tick[31:0], temperature[39:32], mag_x[55:40], mag_y[71:56], mag_z[87:72]
  input  wire logic [mdd_pkg::IN_DATA_W-1:0]     in_tdata,
  // kind[0]
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // door_open[0], state_changed[1], accepted[2], armed_threshold[17:3],
  // comp_origin_x[33:18], comp_origin_y[49:34], comp_origin_z[65:50], zero[71:66]
  output logic      [mdd_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [mdd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mdd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_COMP, S_SQ, S_ACC, S_THO, S_THC, S_DONE
  } state_t;

  mdd_pkg::cfg_regs_t cfg;

  state_t                 state_r;
  logic [1:0]             axis_r;
  logic [1:0]             axis_nxt;
  logic                   kind_r;
  logic [TICK_BITS-1:0]   tick_r;
  logic [TICK_BITS-1:0]   last_tick_r;
  logic [TICK_BITS-1:0]   gap;
  logic                   gap_ok;
  logic signed [7:0]      temp_r;
  logic signed [7:0]      calib_r;
  logic signed [15:0]     mag_r [3];
  logic signed [15:0]     org_r [3];
  logic signed [15:0]     comp_r [3];
  logic [7:0]             dmag_r;
  logic                   delta_neg_r;
  logic [15:0]            dabs_r;
  logic [31:0]            sum_r;
  logic [31:0]            sum_nxt;
  logic                   open_hit_r;
  logic                   closed_hit;
  logic                   door_r;
  logic                   changed_r;
  logic                   accepted_r;
  logic                   out_valid_r;
  logic [mdd_pkg::OUT_DATA_W-1:0] out_data_r;

  logic signed [8:0]      delta_in;
  logic [8:0]             delta_in_neg;
  logic [15:0]            mul_a;
  logic [15:0]            mul_b;
  logic [31:0]            mul_p;
  logic [15:0]            coef_cur;
  logic [15:0]            coef_next;
  logic signed [15:0]     comp_w;
  logic [15:0]            dabs_w;
  logic [14:0]            armed;

  mdd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs_r    (cfg)
  );

  mdd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  mdd_axis u_axis (
    .org       (org_r[axis_r]),
    .sample    (mag_r[axis_r]),
    .pmag      (mul_p[23:8]),
    .delta_neg (delta_neg_r),
    .comp      (comp_w),
    .dabs      (dabs_w)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign delta_in     = {in_tdata[39], in_tdata[39:32]} - {calib_r[7], calib_r};
  assign delta_in_neg = 9'd0 - delta_in;

  assign gap    = tick_r - last_tick_r;
  assign gap_ok = (gap >= TICK_BITS'(cfg.debounce));

  assign axis_nxt   = axis_r + 2'd1;
  assign sum_nxt    = ((axis_r == mdd_pkg::AXIS_X) ? 32'd0 : sum_r) + mul_p;
  assign closed_hit = (sum_r < mul_p);
  assign armed      = door_r ? cfg.closed_thr : cfg.open_thr;

  always_comb begin
    unique case (axis_r)
      mdd_pkg::AXIS_X: begin
        coef_cur  = cfg.coef_x;
        coef_next = cfg.coef_y;
      end
      mdd_pkg::AXIS_Y: begin
        coef_cur  = cfg.coef_y;
        coef_next = cfg.coef_z;
      end
      default: begin
        coef_cur  = cfg.coef_z;
        coef_next = cfg.coef_z;
      end
    endcase
  end

  // operand select for the shared multiplier; the registered product is used in the next state
  always_comb begin
    mul_a = 16'd0;
    mul_b = 16'd0;
    unique case (state_r)
      S_CHECK: begin
        mul_a = {8'd0, dmag_r};
        mul_b = coef_cur;
      end
      S_SQ: begin
        mul_a = dabs_r;
        mul_b = dabs_r;
      end
      S_ACC: begin
        if (axis_r == mdd_pkg::AXIS_Z) begin
          mul_a = {1'b0, cfg.open_thr};
          mul_b = {1'b0, cfg.open_thr};
        end else begin
          mul_a = {8'd0, dmag_r};
          mul_b = coef_next;
        end
      end
      S_THO: begin
        mul_a = {1'b0, cfg.closed_thr};
        mul_b = {1'b0, cfg.closed_thr};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      door_r      <= 1'b0;
      calib_r     <= 8'sd0;
      last_tick_r <= '0;
      axis_r      <= mdd_pkg::AXIS_X;
      for (int i = 0; i < 3; i++) org_r[i] <= 16'sd0;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            kind_r      <= in_tuser;
            tick_r      <= TICK_BITS'(in_tdata[31:0]);
            temp_r      <= in_tdata[39:32];
            mag_r[0]    <= in_tdata[55:40];
            mag_r[1]    <= in_tdata[71:56];
            mag_r[2]    <= in_tdata[87:72];
            delta_neg_r <= delta_in[8];
            dmag_r      <= delta_in[8] ? delta_in_neg[7:0] : delta_in[7:0];
            axis_r      <= mdd_pkg::AXIS_X;
            state_r     <= S_CHECK;
          end
        end
        S_CHECK: begin
          changed_r <= 1'b0;
          if (kind_r) begin
            for (int i = 0; i < 3; i++) begin
              org_r[i]  <= mag_r[i];
              comp_r[i] <= mag_r[i];
            end
            calib_r    <= temp_r;
            door_r     <= 1'b0;
            accepted_r <= 1'b1;
            state_r    <= S_DONE;
          end else if (!gap_ok) begin
            // debounced: nothing changes, compensated fields read zero
            for (int i = 0; i < 3; i++) comp_r[i] <= 16'sd0;
            accepted_r <= 1'b0;
            state_r    <= S_DONE;
          end else begin
            state_r <= S_COMP;
          end
        end
        S_COMP: begin
          comp_r[axis_r] <= comp_w;
          dabs_r         <= dabs_w;
          state_r        <= S_SQ;
        end
        S_SQ: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          sum_r <= sum_nxt;
          if (axis_r == mdd_pkg::AXIS_Z) begin
            state_r <= S_THO;
          end else begin
            axis_r  <= axis_nxt;
            state_r <= S_COMP;
          end
        end
        S_THO: begin
          open_hit_r <= (sum_r > mul_p);
          state_r    <= S_THC;
        end
        S_THC: begin
          priority if (!door_r && open_hit_r) begin
            door_r    <= 1'b1;
            changed_r <= 1'b1;
          end else if (door_r && closed_hit) begin
            door_r    <= 1'b0;
            changed_r <= 1'b1;
          end else begin
            changed_r <= 1'b0;
          end
          accepted_r  <= 1'b1;
          last_tick_r <= tick_r;
          state_r     <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {6'd0, comp_r[2], comp_r[1], comp_r[0], armed,
                            accepted_r, changed_r, door_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mdd_chk.sv */
// Port-level checker for the door detector, bound to the top level.
`default_nettype none

module mdd_chk (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [mdd_pkg::OUT_DATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> !out_tdata[1] && (out_tdata[65:18] == 48'd0))
    else $error("debounced result carries change or compensation data");

  a_change_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[2])
    else $error("state change on a request that was not processed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after taking a request");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind magnetic_door_detector mdd_chk u_mdd_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
